// ===== sv/sba_pkg.sv =====
// sba_pkg: shared types, codes and constants of the skyline block allocator
// used by sba_cell, sba_chain and skyline_block_allocator_core; no dependencies
`default_nettype none

package sba_pkg;

   localparam int SBA_PAGE_SIZE = 128;

   // request function codes
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] rect_width;
      logic [7:0] rect_height;
   } req_type;

   typedef struct packed {
      logic       ok;
      logic [6:0] pos_x;
      logic [7:0] pos_y;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WINDOW,
      ST_SCAN,
      ST_COMMIT,
      ST_RESULT
   } state_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_LOAD,
      CELL_STEP,
      CELL_SHIFT,
      CELL_WRITE
   } cell_op_type;

endpackage

`default_nettype wire

// ===== sv/sba_cell.sv =====
// sba_cell: one column of the skyline, its height plus sliding-window registers
// depends on sba_pkg
`default_nettype none

module sba_cell
   import sba_pkg::*;
#(
   parameter int HW = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_op_type   op,
   input  wire logic          sel,
   input  wire logic [HW-1:0] wr_value,
   input  wire logic [HW-1:0] s_next,
   input  wire logic [HW-1:0] acc_next,
   output logic [HW-1:0]      s_out,
   output logic [HW-1:0]      acc_out
);

   logic [HW-1:0] height_ff, height_in;
   logic [HW-1:0] s_ff, s_in;
   logic [HW-1:0] acc_ff, acc_in;

   always_comb begin
      height_in = height_ff;
      s_in      = s_ff;
      acc_in    = acc_ff;
      case (op)
         CELL_CLEAR: height_in = '0;
         CELL_LOAD: begin
            s_in   = height_ff;
            acc_in = '0;
         end
         CELL_STEP: begin
            acc_in = (s_ff > acc_ff) ? s_ff : acc_ff;
            s_in   = s_next;
         end
         CELL_SHIFT: acc_in = acc_next;
         CELL_WRITE: begin
            if (sel) begin
               height_in = wr_value;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= '0;
      end else begin
         height_ff <= height_in;
      end
      s_ff   <= s_in;
      acc_ff <= acc_in;
   end

   assign s_out   = s_ff;
   assign acc_out = acc_ff;

endmodule

`default_nettype wire

// ===== sv/sba_chain.sv =====
// sba_chain: row of sba_cell columns linked left to right, window write decode
// depends on sba_pkg and sba_cell
`default_nettype none

module sba_chain
   import sba_pkg::*;
#(
   parameter int PAGE_SIZE = SBA_PAGE_SIZE,
   parameter int HW        = $clog2(PAGE_SIZE + 1),
   parameter int CW        = $clog2(PAGE_SIZE)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_op_type   op,
   input  wire logic [CW-1:0] wr_x,
   input  wire logic [CW:0]   wr_w,
   input  wire logic [HW-1:0] wr_value,
   output logic [HW-1:0]      acc_head
);

   localparam logic [HW-1:0] SENTINEL = HW'(PAGE_SIZE);

   logic [HW-1:0] s_q   [PAGE_SIZE];
   logic [HW-1:0] acc_q [PAGE_SIZE];
   logic [CW+1:0] win_lo;
   logic [CW+1:0] win_hi;

   assign win_lo = (CW + 2)'(wr_x);
   assign win_hi = (CW + 2)'(wr_x) + (CW + 2)'(wr_w);

   for (genvar i = 0; i < PAGE_SIZE; i++) begin : g_col
      logic          sel;
      logic [HW-1:0] s_nb;
      logic [HW-1:0] acc_nb;

      assign sel = ((CW + 2)'(i) >= win_lo) && ((CW + 2)'(i) < win_hi);

      if (i == PAGE_SIZE - 1) begin : g_tail
         // columns past the page edge count as full
         assign s_nb   = SENTINEL;
         assign acc_nb = SENTINEL;
      end else begin : g_link
         assign s_nb   = s_q[i+1];
         assign acc_nb = acc_q[i+1];
      end

      sba_cell #(
         .HW (HW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .op       (op),
         .sel      (sel),
         .wr_value (wr_value),
         .s_next   (s_nb),
         .acc_next (acc_nb),
         .s_out    (s_q[i]),
         .acc_out  (acc_q[i])
      );
   end

   assign acc_head = acc_q[0];

endmodule

`default_nettype wire

// ===== sv/skyline_block_allocator_core.sv =====
// skyline_block_allocator_core: top level of the skyline rectangle allocator
// depends on sba_pkg and sba_chain (which uses sba_cell)
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_data  (func, rect_width, rect_height)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_data  (ok, pos_x, pos_y)
//
// clear and rejected widths: the result goes via the result state to the output register
// allocate: the cell chain forms the sliding maximum of each window of rect_width columns,
//   then the window maxima drain past the minimum tracker, and the commit and result
//   states pass the answer on to the output register
// one request in flight; a new request is taken once the previous result is
//   parked in the output register, which may still be stalled
// synchronous reset empties the page at once (no clearing pass) and drops rsp_valid
`default_nettype none

module skyline_block_allocator_core
   import sba_pkg::*;
#(
   parameter int PAGE_SIZE = SBA_PAGE_SIZE
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int HW = $clog2(PAGE_SIZE + 1);   // column height, 0..PAGE_SIZE
   localparam int CW = $clog2(PAGE_SIZE);       // column index
   localparam int LW = (CW + 1 > 8) ? CW + 1 : 8;
   localparam int SW = ((HW > 8) ? HW : 8) + 1;

   localparam logic [CW-1:0] LAST_COL = CW'(PAGE_SIZE - 1);

   // control and datapath registers
   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW:0]   win_w_ff, win_w_in;
   logic [7:0]    win_h_ff, win_h_in;
   logic [HW-1:0] best_ff, best_in;
   logic [CW-1:0] x_ff, x_in;
   logic          found_ff, found_in;
   rsp_type       res_ff, res_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // decode
   logic          req_take;
   logic          is_clear;
   logic          bad_width;
   logic          window_done;
   logic          out_free;
   logic [SW-1:0] top_sum;
   logic          fits;
   cell_op_type   cell_op;
   logic [HW-1:0] acc_head;

   assign req_take    = req_valid && !req_stall;
   assign is_clear    = (req_data.func == FUNC_CLEAR);
   assign bad_width   = (req_data.rect_width == 8'd0)
                     || (LW'(req_data.rect_width) > LW'(PAGE_SIZE));
   assign window_done = ((CW + 1)'(cnt_ff) == (CW + 1)'(win_w_ff - (CW + 1)'(1)));
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   // new top of the window once the rectangle sits on it
   assign top_sum     = SW'(best_ff) + SW'(win_h_ff);
   assign fits        = found_ff && (top_sum <= SW'(PAGE_SIZE));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (is_clear || bad_width) begin
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_WINDOW;
               end
            end
         end
         ST_WINDOW: begin
            if (window_done) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == LAST_COL) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: state_in = ST_RESULT;
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs: request stall and the command broadcast along the chain
   always_comb begin
      req_stall = 1'b1;
      cell_op   = CELL_HOLD;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (is_clear) begin
                  cell_op = CELL_CLEAR;
               end else if (!bad_width) begin
                  cell_op = CELL_LOAD;
               end
            end
         end
         ST_WINDOW: cell_op = CELL_STEP;
         ST_SCAN:   cell_op = CELL_SHIFT;
         ST_COMMIT: begin
            if (fits) begin
               cell_op = CELL_WRITE;
            end
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      cnt_in       = cnt_ff;
      win_w_in     = win_w_ff;
      win_h_in     = win_h_ff;
      best_in      = best_ff;
      x_in         = x_ff;
      found_in     = found_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cnt_in   = '0;
               win_w_in = (CW + 1)'(req_data.rect_width);
               win_h_in = req_data.rect_height;
               best_in  = HW'(PAGE_SIZE);
               x_in     = '0;
               found_in = 1'b0;
               res_in   = '0;
               res_in.ok = is_clear;
            end
         end
         ST_WINDOW: begin
            if (window_done) begin
               cnt_in = '0;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_SCAN: begin
            // window maxima arrive in column order; keep the first strict minimum
            cnt_in = cnt_ff + CW'(1);
            if (acc_head < best_ff) begin
               best_in  = acc_head;
               x_in     = cnt_ff;
               found_in = 1'b1;
            end
         end
         ST_COMMIT: begin
            res_in.ok    = fits;
            res_in.pos_x = found_ff ? 7'(x_ff) : 7'd0;
            res_in.pos_y = found_ff ? 8'(best_ff) : 8'd0;
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
      cnt_ff   <= cnt_in;
      win_w_ff <= win_w_in;
      win_h_ff <= win_h_in;
      best_ff  <= best_in;
      x_ff     <= x_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   // column chain
   sba_chain #(
      .PAGE_SIZE (PAGE_SIZE),
      .HW        (HW),
      .CW        (CW)
   ) u_chain (
      .clock    (clock),
      .reset    (reset),
      .op       (cell_op),
      .wr_x     (x_ff),
      .wr_w     (win_w_ff),
      .wr_value (HW'(top_sum)),
      .acc_head (acc_head)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a clear or rejected transaction goes straight to the result stage
   a_short_path: assert property (@(posedge clock) disable iff (reset)
      (req_take && (is_clear || bad_width)) |=> (state_ff == ST_RESULT))
      else $error("short transaction did not go to result stage");

   // a result only appears out of the result stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESULT))
      else $error("result raised outside result stage");

   // a found candidate always lies below the page top
   a_found_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && found_ff) |-> (best_ff < HW'(PAGE_SIZE)))
      else $error("candidate at or above page top");

   // the chosen window never runs past the last column
   a_window_in_page: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && found_ff)
         |-> ((CW + 2)'(x_ff) + (CW + 2)'(win_w_ff) <= (CW + 2)'(PAGE_SIZE)))
      else $error("chosen window beyond page edge");

   // the window phase never sees a zero width
   a_width_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WINDOW) |-> (win_w_ff != '0))
      else $error("zero width in window phase");

endmodule

`default_nettype wire
